// File: hw/rtl/cifm_pkg.sv
package cifm_pkg;

  localparam int unsigned EntriesDefault = 64;
  localparam int unsigned IdW            = 29;
  localparam int unsigned DataW          = 64;
  localparam int unsigned AgeW           = 8;
  localparam int unsigned IdxW           = 6;
  localparam int unsigned CfgCountW      = 7;
  localparam logic [AgeW-1:0] StaleLimitReset = 8'd100;

  localparam logic [1:0] OpRx   = 2'd0;
  localparam logic [1:0] OpTick = 2'd1;
  localparam logic [1:0] OpRead = 2'd2;
  localparam logic [1:0] OpLoad = 2'd3;

  localparam logic [1:0] KindAccept = 2'd0;
  localparam logic [1:0] KindReject = 2'd1;
  localparam logic [1:0] KindStale  = 2'd2;
  localparam logic [1:0] KindRead   = 2'd3;

  localparam logic RegEntriesInUse = 1'b0;
  localparam logic RegStaleLimit   = 1'b1;

  typedef struct packed {
    logic [1:0]       op;
    logic [IdW-1:0]   key;
    logic [DataW-1:0] mask;
    logic [DataW-1:0] payload;
    logic             restart;
    logic [IdxW-1:0]  entry_index;
    logic [IdW-1:0]   table_id;
  } cmd_t;

  function automatic logic [DataW-1:0] byte_mask(input logic [3:0] dlc);
    logic [DataW-1:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (dlc > 4'(b)) begin
        m[b*8 +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage

// File: hw/rtl/cifm_front.sv
module cifm_front import cifm_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       op_i,
  input  logic             extended_frame_i,
  input  logic [IdW-1:0]   extended_id_i,
  input  logic [10:0]      standard_id_i,
  input  logic [3:0]       data_length_i,
  input  logic [DataW-1:0] payload_i,
  input  logic [1:0]       bus_port_i,
  input  logic [IdxW-1:0]  entry_index_i,
  input  logic [IdW-1:0]   table_id_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output cmd_t             cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t            fifo_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  cmd_t            cmd_in;
  logic            push, pop;

  always_comb begin
    cmd_in.op          = op_i;
    cmd_in.key         = extended_frame_i ? extended_id_i : {18'd0, standard_id_i};
    cmd_in.mask        = byte_mask(data_length_i);
    cmd_in.payload     = payload_i;
    cmd_in.restart     = (bus_port_i < 2'd2);
    cmd_in.entry_index = entry_index_i;
    cmd_in.table_id    = table_id_i;
  end

  assign in_ready_o  = (cnt_q != (PtrW+1)'(Depth));
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule

// File: hw/rtl/cifm_back.sv
module cifm_back import cifm_pkg::*; #(
  parameter int unsigned Entries = EntriesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  cmd_t                 cmd_i,
  input  logic [CfgCountW-1:0] entries_in_use_i,
  input  logic [AgeW-1:0]      stale_limit_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           kind_o,
  output logic [IdxW-1:0]      result_index_o,
  output logic [IdW-1:0]       result_id_o,
  output logic [DataW-1:0]     result_data_o,
  output logic [AgeW-1:0]      result_age_o,
  output logic                 last_o
);

  localparam int unsigned EW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned CW = $clog2(Entries + 1);
  localparam int unsigned NW = (CW > CfgCountW) ? CW : CfgCountW;

  typedef enum logic [2:0] {
    StIdle, StScan, StFetch, StUpdate, StWait, StFlush
  } state_e;

  state_e           state_q;
  cmd_t             cmd_q;
  logic [NW-1:0]    idx_q;
  logic [NW-1:0]    n;
  logic [Entries-1:0] valid_q;
  logic             found_q;
  logic             pend_q;

  logic [IdW-1:0]   id_mem   [Entries];
  logic [DataW-1:0] data_mem [Entries];
  logic [AgeW-1:0]  age_mem  [Entries];
  logic [IdW-1:0]   id_rd_q;
  logic [DataW-1:0] data_rd_q;
  logic [AgeW-1:0]  age_rd_q;
  logic [EW-1:0]    rd_addr;
  logic             rd_en;
  logic             rd_valid_q;

  logic [EW-1:0]    wr_addr;
  logic             data_we, age_we;
  logic [DataW-1:0] data_wd;
  logic [AgeW-1:0]  age_wd;
  logic [DataW-1:0] cur_data;
  logic [AgeW-1:0]  cur_age;

  assign n = (NW'(entries_in_use_i) > NW'(Entries)) ? NW'(Entries) : NW'(entries_in_use_i);
  assign cur_data = rd_valid_q ? data_rd_q : '0;
  assign cur_age  = rd_valid_q ? age_rd_q  : '0;

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && cmd_valid_i && cmd_i.op == OpLoad &&
        32'(cmd_i.entry_index) < Entries) begin
      id_mem[cmd_i.entry_index[EW-1:0]] <= cmd_i.table_id;
    end
    if (data_we) begin
      data_mem[wr_addr] <= data_wd;
    end
    if (age_we) begin
      age_mem[wr_addr] <= age_wd;
    end
    if (rd_en) begin
      id_rd_q   <= id_mem[rd_addr];
      data_rd_q <= data_mem[rd_addr];
      age_rd_q  <= age_mem[rd_addr];
    end
  end

  assign cmd_ready_o = (state_q == StIdle);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_q[EW-1:0];
    if (state_q == StIdle && cmd_valid_i) begin
      rd_en   = 1'b1;
      rd_addr = (cmd_i.op == OpRead) ? cmd_i.entry_index[EW-1:0] : '0;
    end else if (state_q == StScan) begin
      rd_en   = 1'b1;
      rd_addr = EW'(idx_q + 1'b1);
    end else if (state_q == StFetch) begin
      rd_en = 1'b1;
    end
  end

  logic stale;
  logic out_free;
  logic out_set;
  assign stale    = cur_age > stale_limit_i;
  assign out_free = !out_valid_o || out_ready_i;
  assign out_set  = out_free && ((state_q == StWait) || (state_q == StFlush && pend_q));

  always_comb begin
    wr_addr = idx_q[EW-1:0];
    data_we = 1'b0;
    age_we  = 1'b0;
    data_wd = cur_data;
    age_wd  = (cur_age == '1) ? cur_age : cur_age + 1'b1;
    if (cmd_q.op == OpRx) begin
      data_wd = (cur_data & ~cmd_q.mask) | (cmd_q.payload & cmd_q.mask);
      age_wd  = cmd_q.restart ? '0 : cur_age;
    end
    if (state_q == StUpdate && out_free) begin
      if (cmd_q.op == OpRx || !stale) begin
        data_we = 1'b1;
        age_we  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      valid_q        <= '0;
      rd_valid_q     <= 1'b0;
      idx_q          <= '0;
      found_q        <= 1'b0;
      pend_q         <= 1'b0;
      out_valid_o    <= 1'b0;
      kind_o         <= KindReject;
      result_index_o <= '0;
      result_id_o    <= '0;
      result_data_o  <= '0;
      result_age_o   <= '0;
      last_o         <= 1'b0;
    end else begin
      if (out_set) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      if (rd_en) begin
        rd_valid_q <= valid_q[rd_addr];
      end
      if (age_we || data_we) begin
        valid_q[wr_addr] <= 1'b1;
      end
      unique case (state_q)
        StIdle: begin
          if (cmd_valid_i) begin
            cmd_q   <= cmd_i;
            idx_q   <= '0;
            found_q <= 1'b0;
            pend_q  <= 1'b0;
            unique case (cmd_i.op)
              OpRx:    state_q <= (n == '0) ? StWait : StScan;
              OpTick:  state_q <= (n == '0) ? StIdle : StFetch;
              OpRead: begin
                idx_q   <= NW'(cmd_i.entry_index);
                state_q <= StWait;
              end
              default: state_q <= StIdle;
            endcase
          end
        end
        StScan: begin
          if (id_rd_q == cmd_q.key) begin
            found_q <= 1'b1;
            state_q <= StFetch;
          end else if (idx_q + 1'b1 >= n) begin
            state_q <= StWait;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        StFetch: begin
          state_q <= StUpdate;
        end
        StUpdate: begin
          if (out_free) begin
            if (cmd_q.op == OpRx) begin
              result_data_o <= data_wd;
              result_age_o  <= age_wd;
              state_q       <= StWait;
            end else begin
              if (stale && !pend_q) begin
                pend_q         <= 1'b1;
                result_index_o <= IdxW'(idx_q);
                result_id_o    <= id_rd_q;
                result_data_o  <= cur_data;
                result_age_o   <= cur_age;
              end
              state_q <= (stale && pend_q) ? StFlush :
                         ((idx_q + 1'b1 >= n) ? StFlush : StFetch);
              if (!(stale && pend_q)) begin
                idx_q <= idx_q + 1'b1;
              end
            end
          end
        end
        StFlush: begin
          // Push out a held stale report once the output is free.
          if (out_free) begin
            if (pend_q) begin
              kind_o      <= KindStale;
              last_o      <= (idx_q >= n);
              pend_q      <= 1'b0;
            end
            if (idx_q >= n) begin
              state_q <= StIdle;
            end else begin
              state_q <= StFetch;
            end
          end
        end
        StWait: begin
          if (out_free) begin
            last_o      <= 1'b1;
            state_q     <= StIdle;
            if (cmd_q.op == OpRead) begin
              kind_o         <= KindRead;
              result_index_o <= IdxW'(idx_q);
              if (idx_q < n) begin
                result_id_o   <= id_rd_q;
                result_data_o <= cur_data;
                result_age_o  <= cur_age;
              end else begin
                result_id_o   <= '0;
                result_data_o <= '0;
                result_age_o  <= '0;
              end
            end else if (found_q) begin
              kind_o         <= KindAccept;
              result_index_o <= IdxW'(idx_q);
              result_id_o    <= id_rd_q;
            end else begin
              kind_o         <= KindReject;
              result_index_o <= '0;
              result_id_o    <= '0;
              result_data_o  <= '0;
              result_age_o   <= '0;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// File: hw/rtl/can_id_filter_mailbox_timeout.sv
// Channel  | Handshake               | Contents
// input    | in_valid_i / in_ready_o | op, identifiers, length, payload, port, index
// output   | out_valid_o/out_ready_i | kind, index, id, data, age, last
// config   | APB psel/penable        | entries_in_use, stale_limit
// A receive walks the identifier table one entry per cycle.
// A tick fetches and updates each entry in use; stale reports leave through the flush state.
// A read goes from idle to the wait state; a load writes from idle. A two-deep queue sits in front.
// Reset clears the mailboxes and age counters at once through per-entry valid bits.
// Stalls on the output hold the sequencer; the input queue accepts until it is full.
module can_id_filter_mailbox_timeout import cifm_pkg::*; #(
  parameter int unsigned Entries = EntriesDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       op_i,
  input  logic             extended_frame_i,
  input  logic [IdW-1:0]   extended_id_i,
  input  logic [10:0]      standard_id_i,
  input  logic [3:0]       data_length_i,
  input  logic [DataW-1:0] payload_i,
  input  logic [1:0]       bus_port_i,
  input  logic [IdxW-1:0]  entry_index_i,
  input  logic [IdW-1:0]   table_id_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       kind_o,
  output logic [IdxW-1:0]  result_index_o,
  output logic [IdW-1:0]   result_id_o,
  output logic [DataW-1:0] result_data_o,
  output logic [AgeW-1:0]  result_age_o,
  output logic             last_o
);

  logic [CfgCountW-1:0] entries_in_use_q;
  logic [AgeW-1:0]      stale_limit_q;
  logic                 cmd_valid, cmd_ready;
  cmd_t                 cmd;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_in_use_q <= '0;
      stale_limit_q    <= StaleLimitReset;
    end else if (psel && penable && pwrite && paddr == {RegEntriesInUse, 2'b00}) begin
      entries_in_use_q <= pwdata[CfgCountW-1:0];
    end else if (psel && penable && pwrite && paddr == {RegStaleLimit, 2'b00}) begin
      stale_limit_q <= pwdata[AgeW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == {RegEntriesInUse, 2'b00}) begin
      prdata = {25'd0, entries_in_use_q};
    end else if (paddr == {RegStaleLimit, 2'b00}) begin
      prdata = {24'd0, stale_limit_q};
    end
  end

  cifm_front #(.Depth(2)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .extended_frame_i,
    .extended_id_i, .standard_id_i, .data_length_i, .payload_i, .bus_port_i,
    .entry_index_i, .table_id_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  cifm_back #(.Entries(Entries)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .entries_in_use_i(entries_in_use_q), .stale_limit_i(stale_limit_q),
    .out_valid_o, .out_ready_i, .kind_o, .result_index_o, .result_id_o,
    .result_data_o, .result_age_o, .last_o
  );

endmodule

// File: hw/rtl/cifm_checker.sv
module cifm_checker import cifm_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] kind_o,
  input logic       last_o,
  input logic [IdW-1:0] result_id_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o))
    else $error("output transaction dropped while stalled");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KindAccept || kind_o == KindReject || kind_o == KindRead)
    |-> last_o)
    else $error("single-result transaction without last");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KindReject |-> result_id_o == '0)
    else $error("rejected frame carries an identifier");

endmodule

bind can_id_filter_mailbox_timeout cifm_checker u_cifm_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .kind_o, .last_o, .result_id_o
);

// File: tb/can_id_filter_mailbox_timeout_tb.sv
`timescale 1ns / 100ps

module can_id_filter_mailbox_timeout_tb;
  import cifm_pkg::*;

  localparam int unsigned NumEntries = 64;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned SettleCycles = 400;
  localparam logic [2:0] AddrEntriesInUse = {RegEntriesInUse, 2'b00};
  localparam logic [2:0] AddrStaleLimit = {RegStaleLimit, 2'b00};

  typedef struct {
    logic [1:0]       op;
    logic             ext;
    logic [IdW-1:0]   eid;
    logic [10:0]      sid;
    logic [3:0]       dlc;
    logic [DataW-1:0] payload;
    logic [1:0]       port;
    logic [IdxW-1:0]  idx;
    logic [IdW-1:0]   tid;
  } frame_cmd_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IdxW-1:0]  idx;
    logic [IdW-1:0]   id;
    logic [DataW-1:0] data;
    logic [AgeW-1:0]  age;
    logic             last;
  } filter_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [2:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [1:0]       op_i = OpRx;
  logic             extended_frame_i = 1'b0;
  logic [IdW-1:0]   extended_id_i = '0;
  logic [10:0]      standard_id_i = '0;
  logic [3:0]       data_length_i = '0;
  logic [DataW-1:0] payload_i = '0;
  logic [1:0]       bus_port_i = '0;
  logic [IdxW-1:0]  entry_index_i = '0;
  logic [IdW-1:0]   table_id_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [1:0]       kind_o;
  logic [IdxW-1:0]  result_index_o;
  logic [IdW-1:0]   result_id_o;
  logic [DataW-1:0] result_data_o;
  logic [AgeW-1:0]  result_age_o;
  logic             last_o;

  can_id_filter_mailbox_timeout uut (.*);

  always #5 clk_i = ~clk_i;

  logic [IdW-1:0]   id_shadow [NumEntries];
  logic [DataW-1:0] mailbox_shadow [NumEntries];
  logic [AgeW-1:0]  age_shadow [NumEntries];
  logic [CfgCountW-1:0] entries_cfg = '0;
  logic [AgeW-1:0]  stale_cfg = StaleLimitReset;

  frame_cmd_t     pending_cmds [$];
  filter_result_t expected_results [$];
  frame_cmd_t     cur_cmd;
  logic           cmd_taken = 1'b0;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_idle_pct = 0;
  int unsigned    error_count = 0;
  int unsigned    quiet_cycles = 0;

  function automatic int unsigned active_entries();
    return (entries_cfg > NumEntries) ? NumEntries : entries_cfg;
  endfunction

  function automatic filter_result_t make_result(logic [1:0] kind, int unsigned idx,
                                                 logic lst);
    filter_result_t r;
    r.kind = kind;
    r.idx = idx[IdxW-1:0];
    r.id = (kind == KindReject) ? '0 : id_shadow[idx];
    r.data = (kind == KindReject) ? '0 : mailbox_shadow[idx];
    r.age = (kind == KindReject) ? '0 : age_shadow[idx];
    r.last = lst;
    return r;
  endfunction

  task automatic predict_filter(frame_cmd_t c);
    int unsigned n;
    int unsigned hits;
    logic [IdW-1:0] key;
    logic [DataW-1:0] m;
    filter_result_t r;
    n = active_entries();
    hits = 0;
    case (c.op)
      OpRx: begin
        key = c.ext ? c.eid : IdW'(c.sid);
        for (int i = 0; i < n; i++) begin
          if (id_shadow[i] == key) begin
            m = '0;
            for (int b = 0; b < 8; b++) begin
              if (c.dlc > b) m[b*8 +: 8] = 8'hff;
            end
            mailbox_shadow[i] = (mailbox_shadow[i] & ~m) | (c.payload & m);
            if (c.port < 2) age_shadow[i] = '0;
            expected_results.push_back(make_result(KindAccept, i, 1'b1));
            return;
          end
        end
        expected_results.push_back(make_result(KindReject, 0, 1'b1));
      end
      OpTick: begin
        for (int i = 0; i < n; i++) begin
          if (age_shadow[i] > stale_cfg) begin
            expected_results.push_back(make_result(KindStale, i, 1'b0));
            hits++;
          end else if (age_shadow[i] != 8'hff) begin
            age_shadow[i]++;
          end
        end
        if (hits > 0) expected_results[$].last = 1'b1;
      end
      OpRead: begin
        if (c.idx < n) begin
          expected_results.push_back(make_result(KindRead, c.idx, 1'b1));
        end else begin
          r = make_result(KindReject, 0, 1'b1);
          r.kind = KindRead;
          r.idx = c.idx;
          expected_results.push_back(r);
        end
      end
      default: id_shadow[c.idx] = c.tid;
    endcase
  endtask

  function automatic frame_cmd_t random_cmd();
    frame_cmd_t c;
    int unsigned sel;
    int unsigned n;
    int unsigned j;
    n = active_entries();
    c.ext = 1'($urandom_range(1));
    c.eid = IdW'($urandom);
    c.sid = 11'($urandom);
    c.dlc = 4'($urandom);
    c.payload = {$urandom, $urandom};
    c.port = 2'($urandom);
    c.idx = IdxW'($urandom);
    c.tid = ($urandom_range(2) == 0) ? IdW'($urandom_range(2047)) : IdW'($urandom);
    sel = $urandom_range(99);
    if (sel < 45) c.op = OpRx;
    else if (sel < 65) c.op = OpTick;
    else if (sel < 85) c.op = OpRead;
    else c.op = OpLoad;
    if (c.op == OpRx && n > 0 && $urandom_range(4) != 0) begin
      j = $urandom_range(n - 1);
      if (id_shadow[j] < 2048 && $urandom_range(1) == 1) begin
        c.ext = 1'b0;
        c.sid = id_shadow[j][10:0];
      end else begin
        c.ext = 1'b1;
        c.eid = id_shadow[j];
      end
    end
    return c;
  endfunction

  function automatic frame_cmd_t build_cmd(logic [1:0] op, logic ext, logic [IdW-1:0] eid,
                                           logic [10:0] sid, logic [3:0] dlc,
                                           logic [1:0] port, int unsigned idx,
                                           logic [IdW-1:0] tid);
    frame_cmd_t c;
    c.op = op;
    c.ext = ext;
    c.eid = eid;
    c.sid = sid;
    c.dlc = dlc;
    c.payload = {$urandom, $urandom};
    c.port = port;
    c.idx = idx[IdxW-1:0];
    c.tid = tid;
    return c;
  endfunction

  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (addr == AddrEntriesInUse) entries_cfg = value[CfgCountW-1:0];
    else if (addr == AddrStaleLimit) stale_cfg = value[AgeW-1:0];
  endtask

  task automatic drain_and_settle();
    do @(posedge clk_i);
    while (pending_cmds.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_idling(int unsigned phase);
    case (phase % 3)
      0: begin
        send_idle_pct = 32;
        recv_idle_pct = 63;
      end
      1: begin
        send_idle_pct = 63;
        recv_idle_pct = 32;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  task automatic run_random_phase(int unsigned phase, int unsigned n, int unsigned lim,
                                  int unsigned count);
    drain_and_settle();
    write_reg(AddrEntriesInUse, n);
    write_reg(AddrStaleLimit, lim);
    set_idling(phase);
    for (int k = 0; k < count; k++) pending_cmds.push_back(random_cmd());
  endtask

  always @(negedge clk_i) begin
    if (!(in_valid_i && !cmd_taken)) begin
      if (rst_ni && pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_cmd = pending_cmds.pop_front();
        op_i = cur_cmd.op;
        extended_frame_i = cur_cmd.ext;
        extended_id_i = cur_cmd.eid;
        standard_id_i = cur_cmd.sid;
        data_length_i = cur_cmd.dlc;
        payload_i = cur_cmd.payload;
        bus_port_i = cur_cmd.port;
        entry_index_i = cur_cmd.idx;
        table_id_i = cur_cmd.tid;
        in_valid_i = 1'b1;
      end else begin
        in_valid_i = 1'b0;
      end
    end
    out_ready_i = rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    filter_result_t got;
    filter_result_t want;
    cmd_taken <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) begin
      predict_filter(cur_cmd);
    end
    if (out_valid_o && out_ready_i) begin
      got.kind = kind_o;
      got.idx = result_index_o;
      got.id = result_id_o;
      got.data = result_data_o;
      got.age = result_age_o;
      got.last = last_o;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result kind=%0d idx=%0d id=%h data=%h age=%0d last=%0b",
                 $time, got.kind, got.idx, got.id, got.data, got.age, got.last);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got != want) begin
          $display("%0t: mismatch expected kind=%0d idx=%0d id=%h data=%h age=%0d last=%0b",
                   $time, want.kind, want.idx, want.id, want.data, want.age, want.last);
          $display("%0t:          actual kind=%0d idx=%0d id=%h data=%h age=%0d last=%0b",
                   $time, got.kind, got.idx, got.id, got.data, got.age, got.last);
          error_count++;
        end
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [IdW-1:0] id_val;
    for (int i = 0; i < NumEntries; i++) begin
      id_shadow[i] = '0;
      mailbox_shadow[i] = '0;
      age_shadow[i] = '0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // With no entries in use, receive, tick and read stay clear of the identifier table; the loads then fill it.
    set_idling(0);
    pending_cmds.push_back(build_cmd(OpRx, 1'b1, 29'h0c03a1a7, 11'h7ff, 4'd8, 2'd0, 0, '0));
    pending_cmds.push_back(build_cmd(OpTick, 1'b0, '0, '0, 4'd0, 2'd0, 0, '0));
    pending_cmds.push_back(build_cmd(OpRead, 1'b0, '0, '0, 4'd0, 2'd0, 63, '0));
    for (int i = 0; i < NumEntries; i++) begin
      case (i)
        0: id_val = 29'h0c03a1a7;
        1: id_val = 29'h18fef433;
        2: id_val = 29'h7ff;
        3: id_val = '0;
        4: id_val = 29'h1fffffff;
        5: id_val = 29'h18fef433;
        default: id_val = ($urandom_range(1) == 1) ? IdW'($urandom_range(2047))
                                                     : IdW'($urandom);
      endcase
      pending_cmds.push_back(build_cmd(OpLoad, 1'b0, '0, '0, 4'd0, 2'd0, i, id_val));
    end

    drain_and_settle();
    write_reg(AddrEntriesInUse, NumEntries);
    write_reg(AddrStaleLimit, 0);
    set_idling(1);
    pending_cmds.push_back(build_cmd(OpRx, 1'b1, 29'h0c03a1a7, '0, 4'd15, 2'd0, 0, '0));
    pending_cmds.push_back(build_cmd(OpRx, 1'b0, '0, 11'h7ff, 4'd0, 2'd1, 0, '0));
    pending_cmds.push_back(build_cmd(OpRx, 1'b1, 29'h18fef433, '0, 4'd3, 2'd2, 0, '0));
    pending_cmds.push_back(build_cmd(OpRx, 1'b0, '0, 11'h000, 4'd5, 2'd3, 0, '0));
    pending_cmds.push_back(build_cmd(OpRx, 1'b1, 29'h1fffffff, '0, 4'd8, 2'd0, 0, '0));
    pending_cmds.push_back(build_cmd(OpRx, 1'b1, 29'h1234567, 11'h555, 4'd7, 2'd0, 0, '0));
    pending_cmds.push_back(build_cmd(OpTick, 1'b0, '0, '0, 4'd0, 2'd0, 0, '0));
    pending_cmds.push_back(build_cmd(OpTick, 1'b0, '0, '0, 4'd0, 2'd0, 0, '0));
    pending_cmds.push_back(build_cmd(OpRx, 1'b1, 29'h0c03a1a7, '0, 4'd1, 2'd1, 0, '0));
    pending_cmds.push_back(build_cmd(OpRead, 1'b0, '0, '0, 4'd0, 2'd0, 0, '0));
    pending_cmds.push_back(build_cmd(OpRead, 1'b0, '0, '0, 4'd0, 2'd0, 63, '0));

    run_random_phase(2, 7, 3, 30);
    run_random_phase(3, NumEntries, 254, 30);
    run_random_phase(5, 33, 10, 30);

    drain_and_settle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
